>>> hdl/fmpe_pkg.sv
// Shared types, constants and decode tables of the field map evaluator.
package fmpe_pkg;

  // Sizes of the coefficient table.
  localparam int NUM_LAYERS     = 9;
  localparam int COEF_WIDTH     = 40;
  localparam int BARREL_TERMS   = 18;
  localparam int ENDCAP_TERMS   = 17;
  localparam int NUM_COMPONENTS = 3;
  localparam int TABLE_DEPTH    = 2 * NUM_LAYERS * 2 * NUM_COMPONENTS * BARREL_TERMS;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int COEF_W  = 40;
  localparam int CW_EFF  = (COEF_WIDTH < COEF_W) ? COEF_WIDTH : COEF_W;
  localparam int POS_W   = 24;
  localparam int FIELD_W = 32;
  localparam int Q_W     = 48;
  localparam int SUM_W   = 64;
  localparam int TERM_W  = 5;

  // Multiplier geometry: two 24-bit digits per operand.
  localparam int DIG_W = 24;
  localparam int ACC_W = 2 * Q_W;
  localparam int EXT_W = ACC_W + 2;
  localparam int SHIFT_MONO = 20;
  localparam int SHIFT_TERM = 28;

  // Scratch registers holding the coordinate powers and products.
  localparam int SCR_N = 25;
  localparam int SCR_W = 5;
  localparam int MPROG_N = 21;
  localparam logic [SCR_W-1:0] SCR_ONE = 5'd0;
  localparam logic [SCR_W-1:0] SCR_X   = 5'd1;
  localparam logic [SCR_W-1:0] SCR_Z   = 5'd8;
  localparam logic [SCR_W-1:0] SCR_Y   = 5'd15;

  // Commands and result status codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic signed [SUM_W-1:0] FIELD_MAX = 64'sd2147483647;
  localparam logic signed [SUM_W-1:0] FIELD_MIN = -64'sd2147483648;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [2:0] {
    ITEM_LOAD  = 3'b001,
    ITEM_NOFIT = 3'b010,
    ITEM_EVAL  = 3'b100
  } item_kind_t;

  // One classified beat passed from the front to the back.
  typedef struct packed {
    item_kind_t kind;
    logic       is_barrel;
    addr_t      addr;
    coef_t      coef;
    pos_t       x;
    pos_t       y;
    pos_t       z;
  } item_t;

  typedef enum logic [1:0] {
    OPB_X = 2'd0,
    OPB_Y = 2'd1,
    OPB_Z = 2'd2
  } opb_t;

  typedef struct packed {
    logic [SCR_W-1:0] dst;
    logic [SCR_W-1:0] src;
    opb_t             opb;
  } mstep_t;

  typedef struct packed {
    logic start;
    logic term;
    q_t   a;
    q_t   b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    sum_t p;
  } mul_rsp_t;

  // Table address of one coefficient.
  function automatic addr_t coef_addr(input logic barrel, input logic [3:0] layer,
                                      input logic material, input logic [1:0] comp,
                                      input logic [TERM_W-1:0] term_idx);
    int v;
    v = ((((int'(barrel) * NUM_LAYERS + int'(layer)) * 2 + int'(material))
          * NUM_COMPONENTS + int'(comp)) * BARREL_TERMS) + int'(term_idx);
    return addr_t'(v);
  endfunction

  // Program of products that build the powers and cross terms.
  function automatic mstep_t mono_step(input logic [SCR_W-1:0] s);
    mstep_t m;
    m = '{dst: '0, src: '0, opb: OPB_X};
    unique case (s) inside
      [5'd0:5'd5]:  m = '{dst: s + 5'd2, src: s + 5'd1, opb: OPB_X};
      [5'd6:5'd11]: m = '{dst: s + 5'd3, src: s + 5'd2, opb: OPB_Z};
      5'd12:        m = '{dst: 5'd16, src: 5'd15, opb: OPB_Y};
      5'd13:        m = '{dst: 5'd17, src: 5'd16, opb: OPB_Y};
      5'd14:        m = '{dst: 5'd18, src: 5'd1,  opb: OPB_Z};
      5'd15:        m = '{dst: 5'd19, src: 5'd8,  opb: OPB_Y};
      5'd16:        m = '{dst: 5'd20, src: 5'd1,  opb: OPB_Y};
      5'd17:        m = '{dst: 5'd21, src: 5'd16, opb: OPB_Z};
      5'd18:        m = '{dst: 5'd22, src: 5'd9,  opb: OPB_Y};
      5'd19:        m = '{dst: 5'd23, src: 5'd2,  opb: OPB_Y};
      5'd20:        m = '{dst: 5'd24, src: 5'd16, opb: OPB_X};
      default:      m = '{dst: '0, src: '0, opb: OPB_X};
    endcase
    return m;
  endfunction

  // Scratch register that holds the monomial of a term.
  function automatic logic [SCR_W-1:0] term_src(input logic barrel,
                                                input logic [TERM_W-1:0] k);
    logic [SCR_W-1:0] r;
    if (barrel) begin
      r = (k < 5'd3) ? k : k + 5'd5;
    end else if (k < 5'd9) begin
      r = k;
    end else if (k < 5'd15) begin
      r = k + 5'd6;
    end else begin
      r = k + 5'd8;
    end
    return r;
  endfunction

endpackage

>>> hdl/field_map_polynomial_eval.sv
// Top level of the fitted magnetic field evaluator.
//
// Input side is a queue: a beat is taken when push is high and full is low.
// A load beat gives no result; one in range writes one Q8.32 coefficient into the
// 1944-entry table, others are dropped. An evaluate beat gives one result with the
// x, y and z field in Q8.24 tesla and a status (ok, region without fit, saturated).
// Result side is a queue too: the result shows while empty is low and leaves when
// pop is high. A two-entry queue sits between the front end and the back end, and
// a result register sits at the output, so new beats are taken while a result waits.
// An evaluation runs through one shared multiplier that forms four 24 by 24 bit
// partial products per multiply: 21 products build the monomials, and each
// coefficient term is one more product, of a table entry and a monomial.
// A region without fit is answered without using the multiplier.
// Reset clears the queues and the result register; the coefficient table is not
// cleared, and each entry must be loaded before a point that uses it is evaluated.
// When the receiver stalls, the finished result is held; loads still go on, but the
// back end waits before its next result, and full rises once the front queue fills.
module field_map_polynomial_eval (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_command,
  input  logic                               in_is_barrel,
  input  logic [3:0]                         in_layer,
  input  logic                               in_material,
  input  logic [1:0]                         in_component,
  input  logic [fmpe_pkg::TERM_W-1:0]        in_term_index,
  input  logic signed [fmpe_pkg::COEF_W-1:0] in_coef_value,
  input  logic signed [fmpe_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [fmpe_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [fmpe_pkg::POS_W-1:0]  in_pos_z,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [fmpe_pkg::FIELD_W-1:0] out_field_x,
  output logic signed [fmpe_pkg::FIELD_W-1:0] out_field_y,
  output logic signed [fmpe_pkg::FIELD_W-1:0] out_field_z,
  output logic [1:0]                         out_status
);

  fmpe_pkg::item_t head;
  logic            q_empty, q_pop, out_valid;

  fmpe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_command    (in_command),
    .in_is_barrel  (in_is_barrel),
    .in_layer      (in_layer),
    .in_material   (in_material),
    .in_component  (in_component),
    .in_term_index (in_term_index),
    .in_coef_value (in_coef_value),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop)
  );

  fmpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_take  (pop && out_valid),
    .field_x   (out_field_x),
    .field_y   (out_field_y),
    .field_z   (out_field_z),
    .status    (out_status)
  );

  assign empty = !out_valid;

endmodule

>>> hdl/fmpe_front.sv
// Front end: accepts beats, classifies them and queues them for the back end.
module fmpe_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           in_command,
  input  logic                           in_is_barrel,
  input  logic [3:0]                     in_layer,
  input  logic                           in_material,
  input  logic [1:0]                     in_component,
  input  logic [fmpe_pkg::TERM_W-1:0]    in_term_index,
  input  logic signed [fmpe_pkg::COEF_W-1:0] in_coef_value,
  input  logic signed [fmpe_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [fmpe_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [fmpe_pkg::POS_W-1:0]  in_pos_z,
  output fmpe_pkg::item_t                head,
  output logic                           q_empty,
  input  logic                           q_pop
);

  localparam int TERM_W_L = fmpe_pkg::TERM_W;

  fmpe_pkg::item_t q_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            accept, has_fit, load_ok, q_push;
  logic [TERM_W_L-1:0] nterms;
  fmpe_pkg::item_t item;

  // Region and load range checks.
  always_comb begin
    accept  = push && !full;
    has_fit = (int'(in_layer) < fmpe_pkg::NUM_LAYERS) &&
              !((int'(in_layer) == fmpe_pkg::NUM_LAYERS - 1) && in_material);
    nterms  = in_is_barrel ? TERM_W_L'(fmpe_pkg::BARREL_TERMS)
                           : TERM_W_L'(fmpe_pkg::ENDCAP_TERMS);
    load_ok = has_fit && (int'(in_component) < fmpe_pkg::NUM_COMPONENTS) &&
              (in_term_index < nterms);
    q_push  = accept && ((in_command == fmpe_pkg::CMD_EVAL) || load_ok);
  end

  // Build the queued beat; an evaluation carries its region base address.
  always_comb begin
    item.is_barrel = in_is_barrel;
    item.coef      = fmpe_pkg::coef_t'(signed'(in_coef_value[fmpe_pkg::CW_EFF-1:0]));
    item.x         = in_pos_x;
    item.y         = in_pos_y;
    item.z         = in_pos_z;
    if (in_command == fmpe_pkg::CMD_LOAD) begin
      item.kind = fmpe_pkg::ITEM_LOAD;
      item.addr = fmpe_pkg::coef_addr(in_is_barrel, in_layer, in_material,
                                      in_component, in_term_index);
    end else begin
      item.kind = has_fit ? fmpe_pkg::ITEM_EVAL : fmpe_pkg::ITEM_NOFIT;
      item.addr = fmpe_pkg::coef_addr(in_is_barrel, in_layer, in_material, 2'd0, '0);
    end
  end

  assign full    = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign head    = q_r[rp_r];

  // Two-entry queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (q_push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (q_push) q_r[wp_r] <= item;
  end

endmodule

>>> hdl/fmpe_mul.sv
// Shared multiplier: signed 48 by 48 bits from four 24 by 24 partial products, rounded.
module fmpe_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  fmpe_pkg::mul_req_t req,
  output fmpe_pkg::mul_rsp_t rsp
);

  localparam int QW = fmpe_pkg::Q_W;
  localparam int DW = fmpe_pkg::DIG_W;
  localparam int AW = fmpe_pkg::ACC_W;
  localparam int EW = fmpe_pkg::EXT_W;

  logic [QW-1:0]  am_r, bm_r, a_mag, b_mag;
  logic           neg_r, term_r;
  logic [AW-1:0]  acc_r, pp_sh;
  logic [1:0]     step_r, dsum;
  logic           busy_r, fin_r, done_r;
  fmpe_pkg::sum_t p_r;
  logic [DW-1:0]  da, db;
  logic [2*DW-1:0] pp;
  logic [EW-1:0]  ext, sgn, rnd;
  logic signed [EW-1:0] vsum, shifted;

  // Operand magnitudes.
  assign a_mag = req.a[QW-1] ? (~unsigned'(req.a)) + QW'(1) : unsigned'(req.a);
  assign b_mag = req.b[QW-1] ? (~unsigned'(req.b)) + QW'(1) : unsigned'(req.b);

  // One partial product per cycle.
  always_comb begin
    da   = step_r[0] ? am_r[QW-1:DW] : am_r[DW-1:0];
    db   = step_r[1] ? bm_r[QW-1:DW] : bm_r[DW-1:0];
    pp   = (2*DW)'(da) * (2*DW)'(db);
    dsum = {1'b0, step_r[0]} + {1'b0, step_r[1]};
    case (dsum)
      2'd0:    pp_sh = AW'(pp);
      2'd1:    pp_sh = AW'(pp) << DW;
      default: pp_sh = AW'(pp) << (2 * DW);
    endcase
  end

  // Apply sign, add the rounding constant and shift.
  always_comb begin
    ext     = {2'b00, acc_r};
    sgn     = neg_r ? ~ext : ext;
    rnd     = term_r ? (EW'(1) << (fmpe_pkg::SHIFT_TERM - 1))
                     : (EW'(1) << (fmpe_pkg::SHIFT_MONO - 1));
    vsum    = signed'(sgn + rnd + EW'(neg_r));
    shifted = term_r ? (vsum >>> fmpe_pkg::SHIFT_TERM) : (vsum >>> fmpe_pkg::SHIFT_MONO);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= fin_r;
      fin_r  <= busy_r && (step_r == 2'd3);
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      am_r   <= a_mag;
      bm_r   <= b_mag;
      neg_r  <= req.a[QW-1] ^ req.b[QW-1];
      term_r <= req.term;
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
    if (fin_r) p_r <= shifted[fmpe_pkg::SUM_W-1:0];
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule

>>> hdl/fmpe_back.sv
// Back end: coefficient memory, monomial builder, term accumulation and result register.
module fmpe_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fmpe_pkg::item_t                  head,
  input  logic                             q_empty,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_take,
  output logic signed [fmpe_pkg::FIELD_W-1:0] field_x,
  output logic signed [fmpe_pkg::FIELD_W-1:0] field_y,
  output logic signed [fmpe_pkg::FIELD_W-1:0] field_z,
  output logic [1:0]                       status
);

  localparam int FW = fmpe_pkg::FIELD_W;
  localparam int SW = fmpe_pkg::SCR_W;
  localparam int TW = fmpe_pkg::TERM_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MONO  = 7'b0000010,
    ST_MWAIT = 7'b0000100,
    ST_TREAD = 7'b0001000,
    ST_TMUL  = 7'b0010000,
    ST_TWAIT = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  fmpe_pkg::coef_t mem [fmpe_pkg::TABLE_DEPTH];
  fmpe_pkg::coef_t rd_r;
  fmpe_pkg::addr_t rd_addr, base_r;
  fmpe_pkg::q_t    scr_r [fmpe_pkg::SCR_N];
  fmpe_pkg::q_t    scr_rd, opb_val;
  fmpe_pkg::pos_t  x_r, y_r, z_r;
  logic            barrel_r, sat_r;
  logic [SW-1:0]   step_r, scr_idx;
  logic [1:0]      comp_r;
  logic [TW-1:0]   k_r, k_last;
  fmpe_pkg::sum_t  sum_r, sum_add, sum_sat;
  logic            sat_now;
  logic signed [FW-1:0] fx_r, fy_r, fz_r;
  logic            out_valid_r, out_free;
  logic signed [FW-1:0] ox_r, oy_r, oz_r;
  logic [1:0]      ost_r;
  fmpe_pkg::mstep_t   ms;
  fmpe_pkg::mul_req_t req;
  fmpe_pkg::mul_rsp_t rsp;

  logic mem_we, eval_start, nofit_out, mono_done, term_done, last_term, eval_out;

  fmpe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    ms      = fmpe_pkg::mono_step(step_r);
    scr_idx = (state_r == ST_MONO) ? ms.src : fmpe_pkg::term_src(barrel_r, k_r);
    scr_rd  = scr_r[scr_idx];
    case (ms.opb)
      fmpe_pkg::OPB_X: opb_val = fmpe_pkg::q_t'(x_r);
      fmpe_pkg::OPB_Y: opb_val = fmpe_pkg::q_t'(y_r);
      fmpe_pkg::OPB_Z: opb_val = fmpe_pkg::q_t'(z_r);
      default:         opb_val = fmpe_pkg::q_t'(x_r);
    endcase
    req.start = (state_r == ST_MONO) || (state_r == ST_TMUL);
    req.term  = (state_r == ST_TMUL);
    req.a     = (state_r == ST_MONO) ? scr_rd : fmpe_pkg::q_t'(rd_r);
    req.b     = (state_r == ST_MONO) ? opb_val : scr_rd;
    rd_addr   = base_r + fmpe_pkg::addr_t'(int'(comp_r) * fmpe_pkg::BARREL_TERMS)
                + fmpe_pkg::addr_t'(k_r);
  end

  // Sum of terms and saturation to the field range.
  always_comb begin
    k_last  = barrel_r ? TW'(fmpe_pkg::BARREL_TERMS - 1) : TW'(fmpe_pkg::ENDCAP_TERMS - 1);
    sum_add = sum_r + rsp.p;
    sat_now = (sum_add > fmpe_pkg::FIELD_MAX) || (sum_add < fmpe_pkg::FIELD_MIN);
    if (sum_add > fmpe_pkg::FIELD_MAX) begin
      sum_sat = fmpe_pkg::FIELD_MAX;
    end else if (sum_add < fmpe_pkg::FIELD_MIN) begin
      sum_sat = fmpe_pkg::FIELD_MIN;
    end else begin
      sum_sat = sum_add;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    eval_start = 1'b0;
    nofit_out  = 1'b0;
    eval_out   = 1'b0;
    mono_done  = 1'b0;
    term_done  = 1'b0;
    last_term  = (k_r == k_last);
    out_free   = !out_valid_r || out_take;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (head.kind)
            fmpe_pkg::ITEM_LOAD: begin
              mem_we = 1'b1;
              q_pop  = 1'b1;
            end
            fmpe_pkg::ITEM_NOFIT: begin
              if (out_free) begin
                nofit_out = 1'b1;
                q_pop     = 1'b1;
              end
            end
            fmpe_pkg::ITEM_EVAL: begin
              eval_start = 1'b1;
              q_pop      = 1'b1;
              state_nxt  = ST_MONO;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_MONO:  state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (rsp.done) begin
          mono_done = 1'b1;
          state_nxt = (step_r == SW'(fmpe_pkg::MPROG_N - 1)) ? ST_TREAD : ST_MONO;
        end
      end
      ST_TREAD: state_nxt = ST_TMUL;
      ST_TMUL:  state_nxt = ST_TWAIT;
      ST_TWAIT: begin
        if (rsp.done) begin
          term_done = 1'b1;
          state_nxt = (last_term && comp_r == 2'd2) ? ST_OUT : ST_TREAD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          eval_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (nofit_out || eval_out) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (mem_we) mem[head.addr] <= head.coef;
    rd_r <= mem[rd_addr];
  end

  // Evaluation datapath.
  always_ff @(posedge clk) begin
    if (eval_start) begin
      x_r      <= head.x;
      y_r      <= head.y;
      z_r      <= head.z;
      barrel_r <= head.is_barrel;
      base_r   <= head.addr;
      step_r   <= '0;
      comp_r   <= 2'd0;
      k_r      <= '0;
      sum_r    <= '0;
      sat_r    <= 1'b0;
      scr_r[fmpe_pkg::SCR_ONE] <= fmpe_pkg::q_t'(1) <<< fmpe_pkg::SHIFT_MONO;
      scr_r[fmpe_pkg::SCR_X]   <= fmpe_pkg::q_t'(head.x);
      scr_r[fmpe_pkg::SCR_Z]   <= fmpe_pkg::q_t'(head.z);
      scr_r[fmpe_pkg::SCR_Y]   <= fmpe_pkg::q_t'(head.y);
    end
    if (mono_done) begin
      scr_r[ms.dst] <= rsp.p[fmpe_pkg::Q_W-1:0];
      step_r        <= step_r + SW'(1);
    end
    if (term_done) begin
      if (last_term) begin
        k_r    <= '0;
        sum_r  <= '0;
        comp_r <= comp_r + 2'd1;
        if (sat_now) sat_r <= 1'b1;
        case (comp_r)
          2'd0:    fx_r <= sum_sat[FW-1:0];
          2'd1:    fy_r <= sum_sat[FW-1:0];
          default: fz_r <= sum_sat[FW-1:0];
        endcase
      end else begin
        k_r   <= k_r + TW'(1);
        sum_r <= sum_add;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (nofit_out) begin
      ox_r  <= '0;
      oy_r  <= '0;
      oz_r  <= '0;
      ost_r <= fmpe_pkg::STATUS_NOFIT;
    end else if (eval_out) begin
      ox_r  <= fx_r;
      oy_r  <= fy_r;
      oz_r  <= fz_r;
      ost_r <= sat_r ? fmpe_pkg::STATUS_SAT : fmpe_pkg::STATUS_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign field_x   = ox_r;
  assign field_y   = oy_r;
  assign field_z   = oz_r;
  assign status    = ost_r;

endmodule

>>> hdl/fmpe_checker.sv
// Port-level checks of the field map evaluator and their binding to the top level.
module fmpe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic signed [fmpe_pkg::FIELD_W-1:0] out_field_x,
  input logic signed [fmpe_pkg::FIELD_W-1:0] out_field_y,
  input logic signed [fmpe_pkg::FIELD_W-1:0] out_field_z,
  input logic [1:0]                         out_status
);

  // Reset leaves no result pending and the input side open.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side closed after reset");

  // A region without fit reports zero field.
  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == fmpe_pkg::STATUS_NOFIT) |->
    (out_field_x == '0 && out_field_y == '0 && out_field_z == '0))
    else $error("nonzero field for region without fit");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == fmpe_pkg::STATUS_OK ||
                out_status == fmpe_pkg::STATUS_NOFIT ||
                out_status == fmpe_pkg::STATUS_SAT))
    else $error("undefined status code");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_field_x) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind field_map_polynomial_eval fmpe_checker u_fmpe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_field_x (out_field_x),
  .out_field_y (out_field_y),
  .out_field_z (out_field_z),
  .out_status  (out_status)
);

>>> dv/tb.sv
// Testbench for the field map evaluator: coefficient loads, field evaluations and checks.
`timescale 1ns / 1ps

module tb;

  // One input beat and one field result.
  typedef struct {
    logic              cmd;
    logic              barrel;
    logic [3:0]        layer;
    logic              mat;
    logic [1:0]        comp;
    logic [4:0]        term_idx;
    logic signed [39:0] coef;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } beat_t;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic [1:0]         status;
  } field_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_command = 1'b0;
  logic in_is_barrel = 1'b0;
  logic [3:0] in_layer = '0;
  logic in_material = 1'b0;
  logic [1:0] in_component = '0;
  logic [4:0] in_term_index = '0;
  logic signed [39:0] in_coef_value = '0;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic signed [23:0] in_pos_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] out_field_x;
  logic signed [31:0] out_field_y;
  logic signed [31:0] out_field_z;
  logic [1:0] out_status;

  field_map_polynomial_eval dut (.*);

  // Predictor state, stimulus bookkeeping and checking counters.
  logic signed [39:0] coef_mem [0:fmpe_pkg::TABLE_DEPTH-1];
  bit loaded [0:fmpe_pkg::TABLE_DEPTH-1];
  beat_t beats_pending[$];
  field_t fields_due[$];
  beat_t cur_beat;
  int errors = 0;
  int results_seen = 0;
  int beats_sent = 0;
  int send_gap = 0;
  int pop_gap = 0;
  logic hold_rx = 1'b0;

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic bit region_fits(logic [3:0] layer, logic mat);
    return (layer < fmpe_pkg::NUM_LAYERS) && !(layer == fmpe_pkg::NUM_LAYERS - 1 && mat);
  endfunction

  function automatic int slot(logic barrel, logic [3:0] layer, logic mat, int comp, int k);
    return (((int'(barrel) * fmpe_pkg::NUM_LAYERS + int'(layer)) * 2 + int'(mat)) * 3 + comp)
           * fmpe_pkg::BARREL_TERMS + k;
  endfunction

  function automatic int term_count(logic barrel);
    return barrel ? fmpe_pkg::BARREL_TERMS : fmpe_pkg::ENDCAP_TERMS;
  endfunction

  // Q.20 product rounded half up.
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 19)) >>> 20;
  endfunction

  // Q8.32 coefficient times Q.20 monomial, rounded to Q.24.
  function automatic logic signed [127:0] coef_term(logic signed [39:0] c, longint m);
    logic signed [127:0] pc;
    logic signed [127:0] pm;
    pc = c;
    pm = m;
    return (pc * pm + (128'sd1 <<< 27)) >>> 28;
  endfunction

  // Applies one accepted beat to the predicted table and yields its field, if any.
  task automatic predict_field(input beat_t b, output bit has_field, output field_t f);
    longint xp [0:7];
    longint zp [0:7];
    longint yp [0:3];
    longint mono [0:17];
    logic signed [127:0] acc;
    logic signed [31:0] comp_val [0:2];
    has_field = 1'b0;
    f = '{default: '0};
    if (b.cmd == fmpe_pkg::CMD_LOAD) begin
      if (region_fits(b.layer, b.mat) && b.comp < 3 && b.term_idx < term_count(b.barrel))
        coef_mem[slot(b.barrel, b.layer, b.mat, b.comp, b.term_idx)] = b.coef;
      return;
    end
    has_field = 1'b1;
    if (!region_fits(b.layer, b.mat)) begin
      f.status = fmpe_pkg::STATUS_NOFIT;
      return;
    end
    xp[0] = 64'sd1 <<< 20;
    yp[0] = xp[0];
    zp[0] = xp[0];
    xp[1] = b.x;
    yp[1] = b.y;
    zp[1] = b.z;
    for (int k = 2; k < 8; k++) begin
      xp[k] = qmul(xp[k-1], xp[1]);
      zp[k] = qmul(zp[k-1], zp[1]);
    end
    yp[2] = qmul(yp[1], yp[1]);
    yp[3] = qmul(yp[2], yp[1]);
    if (b.barrel) begin
      mono[0] = xp[0];
      mono[1] = xp[1];
      mono[2] = xp[2];
      for (int k = 1; k < 8; k++) mono[2+k] = zp[k];
      mono[10] = yp[1];
      mono[11] = yp[2];
      mono[12] = yp[3];
      mono[13] = qmul(xp[1], zp[1]);
      mono[14] = qmul(zp[1], yp[1]);
      mono[15] = qmul(xp[1], yp[1]);
      mono[16] = qmul(zp[1], yp[2]);
      mono[17] = qmul(zp[2], yp[1]);
    end else begin
      for (int k = 0; k < 8; k++) mono[k] = xp[k];
      mono[8] = zp[1];
      mono[9] = yp[1];
      mono[10] = yp[2];
      mono[11] = yp[3];
      mono[12] = qmul(xp[1], zp[1]);
      mono[13] = qmul(zp[1], yp[1]);
      mono[14] = qmul(yp[1], xp[1]);
      mono[15] = qmul(yp[1], xp[2]);
      mono[16] = qmul(yp[2], xp[1]);
      mono[17] = 0;
    end
    f.status = fmpe_pkg::STATUS_OK;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < term_count(b.barrel); k++)
        acc += coef_term(coef_mem[slot(b.barrel, b.layer, b.mat, c, k)], mono[k]);
      if (acc > 128'sd2147483647) begin
        acc = 128'sd2147483647;
        f.status = fmpe_pkg::STATUS_SAT;
      end else if (acc < -128'sd2147483648) begin
        acc = -128'sd2147483648;
        f.status = fmpe_pkg::STATUS_SAT;
      end
      comp_val[c] = acc[31:0];
    end
    f.fx = comp_val[0];
    f.fy = comp_val[1];
    f.fz = comp_val[2];
  endtask

  // Random values: mostly realistic magnitudes, sometimes extremes or full range.
  function automatic logic signed [39:0] rand_coef(int mode);
    int r;
    r = (mode >= 0) ? mode : $urandom_range(0, 9);
    case (r)
      0: return 40'sh7f_ffff_ffff;
      1: return 40'sh80_0000_0000;
      2: return 40'({$urandom, $urandom});
      3, 4: return 40'(longint'($urandom_range(0, 32'h3ff_ffff)) - 64'sh200_0000);
      default: return 40'(longint'($urandom_range(0, 32'h1ff_ffff)) - 64'sh100_0000);
    endcase
  endfunction

  function automatic logic signed [23:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'sd0;
      3: return 24'($urandom);
      default: return 24'(int'($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  function automatic beat_t make_beat(logic cmd, logic barrel, logic [3:0] layer, logic mat,
                                      logic [1:0] comp, logic [4:0] k, int coef_mode);
    beat_t b;
    b.cmd = cmd;
    b.barrel = barrel;
    b.layer = layer;
    b.mat = mat;
    b.comp = comp;
    b.term_idx = k;
    b.coef = rand_coef(coef_mode);
    b.x = rand_pos();
    b.y = rand_pos();
    b.z = rand_pos();
    return b;
  endfunction

  // Queues one load and records which entries are written.
  task automatic queue_load(beat_t b);
    if (region_fits(b.layer, b.mat) && b.comp < 3 && b.term_idx < term_count(b.barrel))
      loaded[slot(b.barrel, b.layer, b.mat, b.comp, b.term_idx)] = 1'b1;
    beats_pending.push_back(b);
  endtask

  task automatic fill_region(logic barrel, logic [3:0] layer, logic mat, int coef_mode);
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < term_count(barrel); k++)
        queue_load(make_beat(fmpe_pkg::CMD_LOAD, barrel, layer, mat, 2'(c), 5'(k),
                             coef_mode));
  endtask

  function automatic bit region_loaded(logic barrel, logic [3:0] layer, logic mat);
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < term_count(barrel); k++)
        if (!loaded[slot(barrel, layer, mat, c, k)]) return 1'b0;
    return 1'b1;
  endfunction

  // Gap lengths: mostly none or short, a few long, and whole stretches without gaps.
  function automatic int pick_gap(int count);
    int r;
    if ((count / 150) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: offers queued beats on the input side and predicts each accepted one.
  always @(posedge clk) begin
    bit offering;
    bit has_field;
    field_t f;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      offering = push;
      if (push && !full) begin
        predict_field(cur_beat, has_field, f);
        if (has_field) fields_due.push_back(f);
        beats_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (beats_pending.size() > 0) begin
          cur_beat = beats_pending.pop_front();
          in_command <= cur_beat.cmd;
          in_is_barrel <= cur_beat.barrel;
          in_layer <= cur_beat.layer;
          in_material <= cur_beat.mat;
          in_component <= cur_beat.comp;
          in_term_index <= cur_beat.term_idx;
          in_coef_value <= cur_beat.coef;
          in_pos_x <= cur_beat.x;
          in_pos_y <= cur_beat.y;
          in_pos_z <= cur_beat.z;
          offering = 1'b1;
          send_gap = pick_gap(beats_sent);
        end
      end
      push <= offering;
    end
  end

  // Monitor: pops results and compares them with the oldest predicted field.
  always @(posedge clk) begin
    field_t e;
    bit nxt;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (fields_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%0d y=%0d z=%0d status=%0d", $time,
                   out_field_x, out_field_y, out_field_z, out_status);
        end else begin
          e = fields_due.pop_front();
          if (out_field_x !== e.fx || out_field_y !== e.fy || out_field_z !== e.fz ||
              out_status !== e.status) begin
            errors++;
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d status=%0d", $time,
                     e.fx, e.fy, e.fz, e.status);
            $display("%0t:          actual   x=%0d y=%0d z=%0d status=%0d", $time,
                     out_field_x, out_field_y, out_field_z, out_status);
          end
        end
        pop_gap = pick_gap(results_seen + 50);
      end
      if (hold_rx) begin
        nxt = 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      pop <= nxt;
    end
  end

  // Long receiver stall while the sender keeps offering, so the input side fills up.
  initial begin
    wait (results_seen >= 6);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (4000) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Timeout.
  initial begin
    #(40_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    int n_items;
    int r;
    bit found;
    logic b;
    logic [3:0] ly;
    logic m;
    beat_t bt;
    for (int i = 0; i < fmpe_pkg::TABLE_DEPTH; i++) begin
      coef_mem[i] = '0;
      loaded[i] = 1'b0;
    end

    // Directed: regions without fit, ignored loads, saturating extremes.
    beats_pending.push_back(make_beat(fmpe_pkg::CMD_EVAL, 1'b0, 4'd15, 1'b1, 2'd3, 5'd31, -1));
    beats_pending.push_back(make_beat(fmpe_pkg::CMD_EVAL, 1'b1, 4'd9, 1'b0, 2'd0, 5'd0, -1));
    beats_pending.push_back(make_beat(fmpe_pkg::CMD_EVAL, 1'b1, 4'd8, 1'b1, 2'd1, 5'd2, -1));
    queue_load(make_beat(fmpe_pkg::CMD_LOAD, 1'b1, 4'd0, 1'b0, 2'd3, 5'd0, 0));
    queue_load(make_beat(fmpe_pkg::CMD_LOAD, 1'b0, 4'd1, 1'b0, 2'd0, 5'd17, 1));
    queue_load(make_beat(fmpe_pkg::CMD_LOAD, 1'b1, 4'd2, 1'b1, 2'd2, 5'd31, 0));
    queue_load(make_beat(fmpe_pkg::CMD_LOAD, 1'b1, 4'd12, 1'b0, 2'd1, 5'd3, 1));
    queue_load(make_beat(fmpe_pkg::CMD_LOAD, 1'b0, 4'd8, 1'b1, 2'd0, 5'd0, 0));
    fill_region(1'b1, 4'd0, 1'b0, 0);
    fill_region(1'b0, 4'd8, 1'b0, 1);
    for (int i = 0; i < 3; i++) begin
      bt = make_beat(fmpe_pkg::CMD_EVAL, 1'b1, 4'd0, 1'b0, 2'd0, 5'd0, -1);
      bt.x = (i == 0) ? 24'sh7fffff : (i == 1) ? 24'sh800000 : 24'sd0;
      bt.y = bt.x;
      bt.z = bt.x;
      beats_pending.push_back(bt);
      bt.barrel = 1'b0;
      bt.layer = 4'd8;
      beats_pending.push_back(bt);
    end
    n_items = beats_pending.size();

    // Random: region fills followed by evaluations, with noise in between.
    while (n_items < 1400) begin
      r = $urandom_range(0, 99);
      b = 1'($urandom);
      ly = 4'($urandom_range(0, fmpe_pkg::NUM_LAYERS - 1));
      m = 1'($urandom);
      if (r < 6) begin
        if (!region_fits(ly, m)) m = 1'b0;
        fill_region(b, ly, m, $urandom_range(0, 3) == 0 ? -1 : 4);
        n_items += 3 * term_count(b);
      end else if (r < 42) begin
        found = 1'b0;
        for (int t = 0; t < 20 && !found; t++) begin
          b = 1'($urandom);
          ly = 4'($urandom_range(0, fmpe_pkg::NUM_LAYERS - 1));
          m = 1'($urandom);
          found = region_fits(ly, m) && region_loaded(b, ly, m);
        end
        if (found) begin
          beats_pending.push_back(make_beat(fmpe_pkg::CMD_EVAL, b, ly, m, 2'($urandom),
                                            5'($urandom), -1));
          n_items++;
        end
      end else if (r < 50) begin
        ly = 4'($urandom_range(fmpe_pkg::NUM_LAYERS - 1, 15));
        if (ly == fmpe_pkg::NUM_LAYERS - 1) m = 1'b1;
        beats_pending.push_back(make_beat(fmpe_pkg::CMD_EVAL, b, ly, m, 2'($urandom),
                                          5'($urandom), -1));
        n_items++;
      end else if (r < 62) begin
        // Random loads; the block drops any with a bad component, bad term or a region without fit.
        queue_load(make_beat(fmpe_pkg::CMD_LOAD, b, 4'($urandom), m, 2'($urandom),
                             5'($urandom), -1));
        n_items++;
      end else begin
        if (!region_fits(ly, m)) m = 1'b0;
        queue_load(make_beat(fmpe_pkg::CMD_LOAD, b, ly, m, 2'($urandom_range(0, 2)),
                             5'($urandom_range(0, term_count(b) - 1)), -1));
        n_items++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_pending.size() > 0 || push || fields_due.size() > 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/fmpe_pkg.sv
hdl/fmpe_front.sv
hdl/fmpe_mul.sv
hdl/fmpe_back.sv
hdl/field_map_polynomial_eval.sv
hdl/fmpe_checker.sv
dv/tb.sv
